>>> sv/ddfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfl_pkg
// Shared widths, register codes, types and rounding helpers of the
// differential-drive feedback linearizer.
// ----------------------------------------------------------------------------
package ddfl_pkg;

  localparam int DATA_WIDTH  = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int REG_WIDTH   = 16;
  localparam int CFG_AW      = 3;
  localparam int CW          = 19;
  localparam int ZW          = 34;
  localparam int CSTEPS      = 16;
  localparam logic signed [CW-1:0] CORDIC_K = CW'(39797);

  localparam logic signed [ZW-1:0] ATAN [CSTEPS] = '{
    ZW'(34'h020000000), ZW'(34'h012E4051E), ZW'(34'h009FB385B), ZW'(34'h0051111D4),
    ZW'(34'h0028B0D43), ZW'(34'h00145D7E1), ZW'(34'h000A2F61E), ZW'(34'h000517C55),
    ZW'(34'h00028BE53), ZW'(34'h000145F2F), ZW'(34'h0000A2F98), ZW'(34'h0000517CC),
    ZW'(34'h000028BE6), ZW'(34'h0000145F3), ZW'(34'h00000A2FA), ZW'(34'h00000517D)
  };

  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_X           = 3'd0,
    REG_GAIN_Y           = 3'd1,
    REG_INV_LEVER        = 3'd2,
    REG_INV_WHEEL_RADIUS = 3'd3,
    REG_HALF_TRACK       = 3'd4,
    REG_SPIN_RATE        = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        [REG_WIDTH-1:0] gain_x;
    logic        [REG_WIDTH-1:0] gain_y;
    logic        [REG_WIDTH-1:0] inv_lever;
    logic        [REG_WIDTH-1:0] inv_wheel_radius;
    logic        [REG_WIDTH-1:0] half_track;
    logic signed [REG_WIDTH-1:0] spin_rate;
  } ddfl_cfg_t;

  typedef struct packed {
    logic                         spin;
    logic                         clip;
    logic signed [CW-1:0]         c;
    logic signed [CW-1:0]         s;
    logic signed [DATA_WIDTH-1:0] u1;
    logic signed [DATA_WIDTH-1:0] u2;
  } ddfl_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] val;
    logic                         clip;
  } ddfl_sat_t;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int sh);
    logic signed [63:0] half;
    half = 64'sd1 <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic ddfl_sat_t sat(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    ddfl_sat_t r;
    hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) begin
      r.val  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      r.clip = 1'b1;
    end else if (v < lo) begin
      r.val  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      r.clip = 1'b1;
    end else begin
      r.val  = v[DATA_WIDTH-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

>>> sv/ddfl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfl_front
// Request capture, position error, virtual inputs and pipelined CORDIC
// for the heading sine and cosine.
// ----------------------------------------------------------------------------
module ddfl_front import ddfl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic signed [DATA_WIDTH-1:0]  pos_x,
  input  logic signed [DATA_WIDTH-1:0]  pos_y,
  input  logic        [ANGLE_WIDTH-1:0] heading,
  input  logic signed [DATA_WIDTH-1:0]  target_x,
  input  logic signed [DATA_WIDTH-1:0]  target_y,
  input  logic signed [DATA_WIDTH-1:0]  target_vx,
  input  logic signed [DATA_WIDTH-1:0]  target_vy,
  input  logic                          spin_mode,
  input  ddfl_cfg_t                     cfg,
  output logic                          push,
  output ddfl_item_t                    item
);

  localparam int PW = DATA_WIDTH + 18;

  logic                          a_valid_r;
  logic signed [DATA_WIDTH-1:0]  a_px_r, a_py_r, a_tx_r, a_ty_r, a_tvx_r, a_tvy_r;
  logic        [ANGLE_WIDTH-1:0] a_hd_r;
  logic                          a_spin_r;

  logic                          b_valid_r;
  logic signed [PW-1:0]          b_prodx_r, b_prody_r;
  logic signed [DATA_WIDTH-1:0]  b_tvx_r, b_tvy_r;
  logic                          b_spin_r, b_flip_r;
  logic signed [ZW-1:0]          b_z_r;

  logic signed [DATA_WIDTH:0]    ex, ey;
  logic        [31:0]            phase;
  logic        [31:0]            fold;

  logic                          c_valid_r [CSTEPS];
  logic signed [CW-1:0]          c_x_r     [CSTEPS];
  logic signed [CW-1:0]          c_y_r     [CSTEPS];
  logic signed [ZW-1:0]          c_z_r     [CSTEPS];
  logic                          c_flip_r  [CSTEPS];
  logic                          c_spin_r  [CSTEPS];
  logic                          c_clip_r  [CSTEPS];
  logic signed [DATA_WIDTH-1:0]  c_u1_r    [CSTEPS];
  logic signed [DATA_WIDTH-1:0]  c_u2_r    [CSTEPS];

  logic signed [CW-1:0]          sx        [CSTEPS];
  logic signed [CW-1:0]          sy        [CSTEPS];
  logic signed [ZW-1:0]          sz        [CSTEPS];
  logic                          sv_valid  [CSTEPS];
  logic                          s_flip    [CSTEPS];
  logic                          s_spin    [CSTEPS];
  logic                          s_clip    [CSTEPS];
  logic signed [DATA_WIDTH-1:0]  s_u1      [CSTEPS];
  logic signed [DATA_WIDTH-1:0]  s_u2      [CSTEPS];

  ddfl_sat_t                     u1_sat, u2_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
    if (accept) begin
      a_px_r   <= pos_x;
      a_py_r   <= pos_y;
      a_hd_r   <= heading;
      a_tx_r   <= target_x;
      a_ty_r   <= target_y;
      a_tvx_r  <= target_vx;
      a_tvy_r  <= target_vy;
      a_spin_r <= spin_mode;
    end
  end

  always_comb begin
    ex    = (DATA_WIDTH+1)'(a_tx_r) - (DATA_WIDTH+1)'(a_px_r);
    ey    = (DATA_WIDTH+1)'(a_ty_r) - (DATA_WIDTH+1)'(a_py_r);
    phase = 32'({a_hd_r, {(32-ANGLE_WIDTH){1'b0}}});
    fold  = (phase[31] ^ phase[30]) ? {~phase[31], phase[30:0]} : phase;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_prodx_r <= PW'($signed({1'b0, cfg.gain_x}) * ex);
    b_prody_r <= PW'($signed({1'b0, cfg.gain_y}) * ey);
    b_tvx_r   <= a_tvx_r;
    b_tvy_r   <= a_tvy_r;
    b_spin_r  <= a_spin_r;
    b_flip_r  <= phase[31] ^ phase[30];
    b_z_r     <= ZW'($signed(fold));
  end

  always_comb begin
    u1_sat = sat(64'(b_tvx_r) + rnd(64'(b_prodx_r), 12));
    u2_sat = sat(64'(b_tvy_r) + rnd(64'(b_prody_r), 12));
    for (int i = 0; i < CSTEPS; i++) begin
      if (i == 0) begin
        sx[i]       = CORDIC_K;
        sy[i]       = '0;
        sz[i]       = b_z_r;
        sv_valid[i] = b_valid_r;
        s_flip[i]   = b_flip_r;
        s_spin[i]   = b_spin_r;
        s_clip[i]   = u1_sat.clip | u2_sat.clip;
        s_u1[i]     = u1_sat.val;
        s_u2[i]     = u2_sat.val;
      end else begin
        sx[i]       = c_x_r[i-1];
        sy[i]       = c_y_r[i-1];
        sz[i]       = c_z_r[i-1];
        sv_valid[i] = c_valid_r[i-1];
        s_flip[i]   = c_flip_r[i-1];
        s_spin[i]   = c_spin_r[i-1];
        s_clip[i]   = c_clip_r[i-1];
        s_u1[i]     = c_u1_r[i-1];
        s_u2[i]     = c_u2_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CSTEPS; i++) begin
      if (!rst_n) begin
        c_valid_r[i] <= 1'b0;
      end else begin
        c_valid_r[i] <= sv_valid[i];
      end
      if (sz[i] >= 0) begin
        c_x_r[i] <= sx[i] - (sy[i] >>> i);
        c_y_r[i] <= sy[i] + (sx[i] >>> i);
        c_z_r[i] <= sz[i] - ATAN[i];
      end else begin
        c_x_r[i] <= sx[i] + (sy[i] >>> i);
        c_y_r[i] <= sy[i] - (sx[i] >>> i);
        c_z_r[i] <= sz[i] + ATAN[i];
      end
      c_flip_r[i] <= s_flip[i];
      c_spin_r[i] <= s_spin[i];
      c_clip_r[i] <= s_clip[i];
      c_u1_r[i]   <= s_u1[i];
      c_u2_r[i]   <= s_u2[i];
    end
  end

  always_comb begin
    push      = c_valid_r[CSTEPS-1];
    item.spin = c_spin_r[CSTEPS-1];
    item.clip = c_clip_r[CSTEPS-1];
    item.c    = c_flip_r[CSTEPS-1] ? -c_x_r[CSTEPS-1] : c_x_r[CSTEPS-1];
    item.s    = c_flip_r[CSTEPS-1] ? -c_y_r[CSTEPS-1] : c_y_r[CSTEPS-1];
    item.u1   = c_u1_r[CSTEPS-1];
    item.u2   = c_u2_r[CSTEPS-1];
  end

endmodule

>>> sv/ddfl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfl_queue
// Four-entry request queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module ddfl_queue import ddfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ddfl_item_t push_item,
  input  logic       pop,
  output logic       not_empty,
  output logic       near_full,
  output ddfl_item_t pop_item
);

  ddfl_item_t mem_r [4];
  logic [1:0] wptr_r, rptr_r;
  logic [2:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 2'd1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 2'd1;
      end
      count_r <= count_r + 3'(push) - 3'(pop);
    end
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  assign not_empty = (count_r != 3'd0);
  assign near_full = (count_r >= 3'd3);
  assign pop_item  = mem_r[rptr_r];

endmodule

>>> sv/ddfl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddfl_back
// Rotation into forward speed and turn rate, lever scaling and wheel
// mapping, with saturation of forward speed, turn rate and wheel rates.
// ----------------------------------------------------------------------------
module ddfl_back import ddfl_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  ddfl_item_t                   item,
  input  ddfl_cfg_t                    cfg,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] left,
  output logic signed [DATA_WIDTH-1:0] right,
  output logic                         clip
);

  localparam int MW = CW + DATA_WIDTH;
  localparam int LW = DATA_WIDTH + 17;
  localparam int DW9 = DATA_WIDTH + 9;
  localparam int WW = DATA_WIDTH + 27;

  logic [5:0]                   valid_r;

  logic signed [MW-1:0]         p_cu1_r, p_su2_r, p_cu2_r, p_su1_r;
  logic                         p_spin_r, p_clip_r;

  logic signed [DATA_WIDTH-1:0] r_v_r, r_t_r;
  logic                         r_spin_r, r_clip_r;

  logic signed [DATA_WIDTH-1:0] w_v_r, w_w_r;
  logic                         w_clip_r;

  logic signed [DW9-1:0]        d_d_r;
  logic signed [DATA_WIDTH-1:0] d_v_r;
  logic                         d_clip_r;

  logic signed [WW-1:0]         m_l_r, m_r_r;
  logic                         m_clip_r;

  ddfl_sat_t                    v_sat, t_sat, w_sat, sp_sat, l_sat, r_sat;
  logic signed [LW-1:0]         tl;
  logic signed [LW-1:0]         hw;
  logic signed [DW9:0]          vmd, vpd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p_cu1_r  <= MW'(item.c * item.u1);
    p_su2_r  <= MW'(item.s * item.u2);
    p_cu2_r  <= MW'(item.c * item.u2);
    p_su1_r  <= MW'(item.s * item.u1);
    p_spin_r <= item.spin;
    p_clip_r <= item.clip;
  end

  always_comb begin
    v_sat = sat(rnd(64'(p_cu1_r) + 64'(p_su2_r), 16));
    t_sat = sat(rnd(64'(p_cu2_r) - 64'(p_su1_r), 16));
  end

  always_ff @(posedge clk) begin
    r_v_r    <= v_sat.val;
    r_t_r    <= t_sat.val;
    r_spin_r <= p_spin_r;
    r_clip_r <= p_clip_r | v_sat.clip | t_sat.clip;
  end

  always_comb begin
    tl     = LW'(r_t_r * $signed({1'b0, cfg.inv_lever}));
    w_sat  = sat(rnd(64'(tl), 8));
    sp_sat = sat(64'(cfg.spin_rate));
  end

  always_ff @(posedge clk) begin
    if (r_spin_r) begin
      w_v_r    <= '0;
      w_w_r    <= sp_sat.val;
      w_clip_r <= sp_sat.clip;
    end else begin
      w_v_r    <= r_v_r;
      w_w_r    <= w_sat.val;
      w_clip_r <= r_clip_r | w_sat.clip;
    end
  end

  always_comb begin
    hw = LW'(w_w_r * $signed({1'b0, cfg.half_track}));
  end

  always_ff @(posedge clk) begin
    d_d_r    <= DW9'(rnd(64'(hw), 8));
    d_v_r    <= w_v_r;
    d_clip_r <= w_clip_r;
  end

  always_comb begin
    vmd = (DW9+1)'(d_v_r) - (DW9+1)'(d_d_r);
    vpd = (DW9+1)'(d_v_r) + (DW9+1)'(d_d_r);
  end

  always_ff @(posedge clk) begin
    m_l_r    <= WW'(vmd * $signed({1'b0, cfg.inv_wheel_radius}));
    m_r_r    <= WW'(vpd * $signed({1'b0, cfg.inv_wheel_radius}));
    m_clip_r <= d_clip_r;
  end

  always_comb begin
    l_sat = sat(rnd(64'(m_l_r), 8));
    r_sat = sat(rnd(64'(m_r_r), 8));
  end

  always_ff @(posedge clk) begin
    left  <= l_sat.val;
    right <= r_sat.val;
    clip  <= m_clip_r | l_sat.clip | r_sat.clip;
  end

  assign out_valid = valid_r[5];

endmodule

>>> sv/diff_drive_feedback_linearizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_feedback_linearizer
// Wheel-rate commands for a differential-drive robot by feedback
// linearization about a lever point.
//
// A request (pose, setpoint, spin flag) is taken at a rising edge with
// start high and busy low. One request may enter every cycle while busy is low.
// Each request gives one result: out_strobe is high for exactly one
// cycle with left/right wheel rates and the clipped flag.
// The strobe follows the accepting edge through the 16-stage heading
// CORDIC in the front pipeline, a pass through the request queue and six
// stages of multiplies and rounding in the back pipeline. Throughput is
// one request per cycle while busy is low.
// The receiver cannot stall; the back pipeline drains the queue every
// cycle, so busy stays low in normal use.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at the
// edge; unknown indexes are dropped.
// Reset (rst_n low, synchronous) empties the pipelines and the queue and
// restores the register defaults.
// ----------------------------------------------------------------------------
module diff_drive_feedback_linearizer import ddfl_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [DATA_WIDTH-1:0]  in_pos_x,
  input  logic signed [DATA_WIDTH-1:0]  in_pos_y,
  input  logic        [ANGLE_WIDTH-1:0] in_heading,
  input  logic signed [DATA_WIDTH-1:0]  in_target_x,
  input  logic signed [DATA_WIDTH-1:0]  in_target_y,
  input  logic signed [DATA_WIDTH-1:0]  in_target_vx,
  input  logic signed [DATA_WIDTH-1:0]  in_target_vy,
  input  logic                          in_spin_mode,
  output logic                          out_strobe,
  output logic signed [DATA_WIDTH-1:0]  out_left_wheel_rate,
  output logic signed [DATA_WIDTH-1:0]  out_right_wheel_rate,
  output logic                          out_clipped,
  input  logic                          cfg_we,
  input  logic        [CFG_AW-1:0]      cfg_addr,
  input  logic        [REG_WIDTH-1:0]   cfg_wdata
);

  ddfl_cfg_t  cfg_r;
  logic       accept;
  logic       push, not_empty, near_full;
  ddfl_item_t push_item, pop_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_x           <= 16'd410;
      cfg_r.gain_y           <= 16'd410;
      cfg_r.inv_lever        <= 16'd2560;
      cfg_r.inv_wheel_radius <= 16'd2560;
      cfg_r.half_track       <= 16'd51;
      cfg_r.spin_rate        <= 16'sd128;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_GAIN_X:           cfg_r.gain_x           <= cfg_wdata;
        REG_GAIN_Y:           cfg_r.gain_y           <= cfg_wdata;
        REG_INV_LEVER:        cfg_r.inv_lever        <= cfg_wdata;
        REG_INV_WHEEL_RADIUS: cfg_r.inv_wheel_radius <= cfg_wdata;
        REG_HALF_TRACK:       cfg_r.half_track       <= cfg_wdata;
        REG_SPIN_RATE:        cfg_r.spin_rate        <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign busy   = near_full;
  assign accept = start & ~busy;

  ddfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .heading   (in_heading),
    .target_x  (in_target_x),
    .target_y  (in_target_y),
    .target_vx (in_target_vx),
    .target_vy (in_target_vy),
    .spin_mode (in_spin_mode),
    .cfg       (cfg_r),
    .push      (push),
    .item      (push_item)
  );

  ddfl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (not_empty),
    .not_empty (not_empty),
    .near_full (near_full),
    .pop_item  (pop_item)
  );

  ddfl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (not_empty),
    .item      (pop_item),
    .cfg       (cfg_r),
    .out_valid (out_strobe),
    .left      (out_left_wheel_rate),
    .right     (out_right_wheel_rate),
    .clip      (out_clipped)
  );

endmodule
